// ----- design/kcct_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package kcct_pkg;

  localparam int NODES_DEFAULT = 64;
  localparam int CNT_W         = 7;
  localparam int TIME_W        = 32;
  localparam int ID_W          = 6;
  localparam int CMD_W         = 3;
  localparam int KAPPA_W       = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int SET_W         = 64;
  localparam int IN_W          = 112;
  localparam int OUT_W         = 144;

  localparam logic [KAPPA_W-1:0] KAPPA_RESET     = 7'd3;
  localparam logic [TIME_W-1:0]  THRESHOLD_RESET = 32'd1024;
  localparam logic [ID_W-1:0]    SELF_RESET      = 6'd0;

  localparam logic [CMD_W-1:0] CMD_CONNECT    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DISCONNECT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_SET   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LOAD_ROW   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MERGE      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_BIDIR      = 3'd5;
  localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_KAPPA     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SELF      = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SELF,
    S_ADV,
    S_ADVWB,
    S_MPEER,
    S_MPEER2,
    S_MLOOP,
    S_MFIN,
    S_BID,
    S_OUT,
    S_OUT2
  } state_t;

endpackage

`default_nettype wire

// ----- design/k_clique_community_tracker_unit.sv -----
// k-clique community tracker for one node.
// Input channel s_*: one beat carries a command with its time, peer, row
// index and node set. Output channel m_*: one result beat per input beat,
// giving the community, its size, a familiar row, a contact count and
// whether the peer is a member.
// Configuration: wr_en/wr_index/wr_data writes kappa (0), familiar
// threshold (1) or self id (2); write only while idle.
// Load commands and the unused command go from the start state straight
// to the output states. Connect, disconnect and query walk the
// contact-time memory (one peer a cycle). Merge adds a walk over the
// staged rows with the shared popcount unit, or skips it when the peer is
// not admitted. The bidirectional check passes through its check state.
// After each item the block returns to idle.
// s_tready is high only while the block is idle; one item is in work at a
// time. A finished result sits in the output register, so the next beat is
// taken while it waits; a stalled receiver holds the block at the end of
// the following item.
// Reset (rst, synchronous) clears contact times and familiar rows at once
// through valid bits, clears connections, sets members to the self bit
// and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module k_clique_community_tracker_unit
  import kcct_pkg::*;
#(
  parameter int NODES = NODES_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // command[2:0], time_now[34:3], peer_id[40:35], row_index[46:41],
  // row_bits[110:47], zero[111]
  input  wire logic [IN_W-1:0]      s_tdata,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // member_set[63:0], member_count[70:64], familiar_row[134:71],
  // contacts_in_set[141:135], peer_is_member[142], zero[143]
  output logic      [OUT_W-1:0]     m_tdata,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [TIME_W-1:0]    wr_data
);

  localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam logic [IW:0]   NODES_C  = (IW+1)'(NODES);
  localparam logic [ID_W:0] NODES_ID = (ID_W+1)'(NODES);

  state_t state, state_next;

  logic [KAPPA_W-1:0] kappa;
  logic [TIME_W-1:0]  threshold;
  logic [ID_W-1:0]    self_id;

  logic [CMD_W-1:0]   cmd_r;
  logic [TIME_W-1:0]  now_r;
  logic [ID_W-1:0]    peer_r;
  logic [ID_W-1:0]    row_r;
  logic [NODES-1:0]   bits_r;

  logic [NODES-1:0]   connected;
  logic [NODES-1:0]   members;
  logic [NODES-1:0]   peer_members;
  logic [NODES-1:0]   self_row;
  logic [TIME_W-1:0]  last_update;
  logic [TIME_W-1:0]  delta;

  logic [IW:0]        idx;
  logic               pv;
  logic [IW-1:0]      pi;

  logic [CNT_W-1:0]   mcount;

  logic               self_ok, peer_ok, row_ok;
  logic [IW-1:0]      self_idx, peer_idx, row_idx;
  logic [NODES-1:0]   pb, self_bit, cfg_self_bit;
  logic               idx_end, time_cmd;

  logic [TIME_W-1:0]  ct_q, fam_unused;
  logic [NODES-1:0]   fam_q, pr_q;
  logic [TIME_W:0]    sum;
  logic [TIME_W-1:0]  ct_sat;
  logic               fam_hit;

  logic [NODES-1:0]   pop_in;
  logic [CNT_W-1:0]   pop_out;
  logic               admit, peer_join, merge_hit, bid_hit;

  logic               ct_we, fam_we, pr_we;
  logic [IW-1:0]      ct_raddr, fam_raddr, pr_raddr, fam_waddr, pr_waddr;
  logic [NODES-1:0]   fam_wdata;

  logic               out_free;

  assign self_ok  = {1'b0, self_id} < NODES_ID;
  assign peer_ok  = {1'b0, peer_r} < NODES_ID;
  assign row_ok   = {1'b0, row_r} < NODES_ID;
  assign self_idx = self_id[IW-1:0];
  assign peer_idx = peer_r[IW-1:0];
  assign row_idx  = row_r[IW-1:0];
  assign pb       = peer_ok ? (NODES'(1) << peer_idx) : '0;
  assign self_bit = self_ok ? (NODES'(1) << self_idx) : '0;
  assign cfg_self_bit = ({1'b0, wr_data[ID_W-1:0]} < NODES_ID)
                      ? (NODES'(1) << wr_data[IW-1:0]) : '0;
  assign idx_end  = (idx == NODES_C);
  assign time_cmd = (cmd_r == CMD_CONNECT) || (cmd_r == CMD_DISCONNECT) ||
                    (cmd_r == CMD_MERGE) || (cmd_r == CMD_QUERY);

  assign sum     = {1'b0, ct_q} + {1'b0, delta};
  assign ct_sat  = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
  assign fam_hit = pv && connected[pi] && (ct_sat >= threshold) && self_ok &&
                   !self_row[pi];

  kcct_popcnt #(.W(NODES)) u_pop (
    .din   (pop_in),
    .count (pop_out)
  );

  assign admit     = ({1'b0, pop_out} + 8'd1) >= {1'b0, kappa};
  assign peer_join = peer_ok && !members[peer_idx] && admit;
  assign merge_hit = pv && peer_members[pi] && !members[pi] && admit;
  assign bid_hit   = peer_ok && ((bits_r & self_bit) != '0) && ((members & pb) == '0);
  assign out_free  = !m_tvalid || m_tready;
  assign fam_unused = '0;

  always_comb begin
    unique case (state)
      S_OUT:   pop_in = members;
      S_OUT2:  pop_in = connected & bits_r;
      default: pop_in = pr_q & members;
    endcase
  end

  kcct_mem #(.DEPTH(NODES), .WIDTH(TIME_W), .AW(IW), .HAS_VALID(1'b1)) u_ct (
    .clk (clk), .rst (rst), .we (ct_we), .waddr (pi), .wdata (ct_sat),
    .raddr (ct_raddr), .rdata (ct_q)
  );

  kcct_mem #(.DEPTH(NODES), .WIDTH(NODES), .AW(IW), .HAS_VALID(1'b1)) u_fam (
    .clk (clk), .rst (rst), .we (fam_we), .waddr (fam_waddr), .wdata (fam_wdata),
    .raddr (fam_raddr), .rdata (fam_q)
  );

  kcct_mem #(.DEPTH(NODES), .WIDTH(NODES), .AW(IW), .HAS_VALID(1'b0)) u_pr (
    .clk (clk), .rst (rst), .we (pr_we), .waddr (pr_waddr), .wdata (bits_r),
    .raddr (pr_raddr), .rdata (pr_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (s_tvalid) state_next = S_START;
      S_START: begin
        if (time_cmd) state_next = S_SELF;
        else if (cmd_r == CMD_BIDIR) state_next = S_BID;
        else state_next = S_OUT;
      end
      S_SELF:   state_next = S_ADV;
      S_ADV:    if (idx_end && !pv) state_next = S_ADVWB;
      S_ADVWB:  state_next = (cmd_r == CMD_MERGE && peer_ok) ? S_MPEER : S_OUT;
      S_MPEER:  state_next = S_MPEER2;
      S_MPEER2: state_next = (members[peer_idx] || peer_join) ? S_MLOOP : S_MFIN;
      S_MLOOP:  if (idx_end && !pv) state_next = S_MFIN;
      S_MFIN:   state_next = S_OUT;
      S_BID:    state_next = S_OUT;
      S_OUT:    state_next = S_OUT2;
      S_OUT2:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == S_IDLE);
    ct_raddr  = idx[IW-1:0];
    ct_we     = (state == S_ADV) && pv && connected[pi];
    pr_raddr  = (state == S_MPEER) ? peer_idx : idx[IW-1:0];
    pr_we     = (state == S_START) && (cmd_r == CMD_LOAD_ROW) && row_ok;
    pr_waddr  = row_idx;
    fam_raddr = ((state == S_OUT) || (state == S_OUT2)) ? row_idx : self_idx;
    fam_we    = 1'b0;
    fam_waddr = self_idx;
    fam_wdata = self_row;
    unique case (state)
      S_ADVWB: fam_we = self_ok;
      S_MLOOP: begin
        fam_we    = merge_hit;
        fam_waddr = pi;
        fam_wdata = pr_q;
      end
      S_MFIN: begin
        fam_we    = 1'b1;
        fam_waddr = peer_idx;
        fam_wdata = peer_members;
      end
      S_BID: begin
        fam_we    = bid_hit;
        fam_wdata = fam_q | pb;
      end
      default: fam_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      kappa       <= KAPPA_RESET;
      threshold   <= THRESHOLD_RESET;
      self_id     <= SELF_RESET;
      connected   <= '0;
      members     <= ({1'b0, SELF_RESET} < NODES_ID) ? (NODES'(1) << SELF_RESET[IW-1:0]) : '0;
      last_update <= '0;
      m_tvalid    <= 1'b0;
      pv          <= 1'b0;
      idx         <= '0;
    end else begin
      state <= state_next;
      if ((state == S_OUT2) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (wr_en) begin
        unique case (wr_index)
          REG_KAPPA:     kappa     <= wr_data[KAPPA_W-1:0];
          REG_THRESHOLD: threshold <= wr_data;
          REG_SELF: begin
            self_id <= wr_data[ID_W-1:0];
            members <= members | cfg_self_bit;
          end
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (s_tvalid) begin
          cmd_r  <= s_tdata[2:0];
          now_r  <= s_tdata[34:3];
          peer_r <= s_tdata[40:35];
          row_r  <= s_tdata[46:41];
          bits_r <= s_tdata[47 +: NODES];
        end
        S_START: begin
          if (time_cmd) begin
            delta       <= (now_r >= last_update) ? (now_r - last_update) : '0;
            last_update <= now_r;
          end
          if (cmd_r == CMD_LOAD_SET) peer_members <= bits_r;
        end
        S_SELF: begin
          self_row <= fam_q;
          idx      <= '0;
          pv       <= 1'b0;
        end
        S_ADV: begin
          if (fam_hit) begin
            self_row[pi] <= 1'b1;
            members[pi]  <= 1'b1;
          end
          if (!idx_end) begin
            pv  <= 1'b1;
            pi  <= idx[IW-1:0];
            idx <= idx + 1'b1;
          end else begin
            pv <= 1'b0;
          end
        end
        S_ADVWB: begin
          if (cmd_r == CMD_CONNECT) connected <= connected | pb;
          if (cmd_r == CMD_DISCONNECT) connected <= connected & ~pb;
        end
        S_MPEER2: begin
          if (peer_join) members[peer_idx] <= 1'b1;
          idx <= '0;
          pv  <= 1'b0;
        end
        S_MLOOP: begin
          if (merge_hit) members[pi] <= 1'b1;
          if (!idx_end) begin
            pv  <= 1'b1;
            pi  <= idx[IW-1:0];
            idx <= idx + 1'b1;
          end else begin
            pv <= 1'b0;
          end
        end
        S_BID: if (bid_hit) members <= members | pb;
        S_OUT: mcount <= pop_out;
        S_OUT2: if (out_free) begin
          m_tdata[63:0]   <= SET_W'(members);
          m_tdata[70:64]  <= mcount;
          m_tdata[134:71] <= row_ok ? SET_W'(fam_q) : SET_W'(fam_unused);
          m_tdata[141:135] <= pop_out;
          m_tdata[142]    <= (members & pb) != '0;
          m_tdata[143]    <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/kcct_popcnt.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kcct_popcnt
  import kcct_pkg::*;
#(
  parameter int W = NODES_DEFAULT
) (
  input  wire logic [W-1:0]     din,
  output logic      [CNT_W-1:0] count
);

  always_comb begin
    count = '0;
    for (int i = 0; i < W; i++) begin
      count = count + CNT_W'(din[i]);
    end
  end

endmodule

`default_nettype wire

// ----- design/kcct_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kcct_mem
  import kcct_pkg::*;
#(
  parameter int DEPTH     = NODES_DEFAULT,
  parameter int WIDTH     = 32,
  parameter int AW        = 6,
  parameter bit HAS_VALID = 1'b1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  if (HAS_VALID) begin : g_valid
    logic [DEPTH-1:0] valid;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid <= '0;
      end else if (we) begin
        valid[waddr] <= 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      rdata <= valid[raddr] ? mem[raddr] : '0;
    end
  end else begin : g_plain
    always_ff @(posedge clk) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
